/* design/ccrs_pkg.sv */
// shared types and constants for the cluster chain read sequencer
// no dependencies; imported by ccrs_link and cluster_chain_read_sequencer_top
package ccrs_pkg;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_FAT_BASE_LBA    = 2'd0;
  localparam logic [1:0] CFG_DATA_BASE_LBA   = 2'd1;
  localparam logic [1:0] CFG_CLUSTER_SECTORS = 2'd2;

  localparam logic [31:0] CHAIN_END          = 32'h0FFF_FFF8;
  localparam logic [31:0] ENTRY_MASK         = 32'h0FFF_FFFF;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;
  localparam logic [7:0]  MAX_CLUSTER_SECTORS = 8'd128;
  localparam int          SECTOR_SHIFT       = 9;
  localparam logic [17:0] SECTOR_ROUND       = 18'd511;

  typedef struct packed {
    logic        req_type;
    logic [31:0] cluster_value;
    logic [31:0] file_length;
    logic        fat_read_failed;
  } ccrs_in_t;

  typedef struct packed {
    logic        issue_read;
    logic [31:0] read_lba;
    logic [7:0]  read_sectors;
    logic [16:0] read_bytes;
    logic [31:0] lookup_lba;
    logic [8:0]  lookup_offset;
    logic        done_res;
    logic [31:0] loaded_total;
  } ccrs_out_t;

  typedef struct packed {
    logic [31:0] fat_base_lba;
    logic [31:0] data_base_lba;
    logic [7:0]  cluster_sectors;
  } ccrs_cfg_t;

  typedef struct packed {
    logic        active;
    logic [31:0] remaining;
    logic [31:0] loaded;
  } ccrs_state_t;

endpackage

/* design/ccrs_link.sv */
// one chain link step: read request and byte counters from a transaction
// depends on ccrs_pkg
module ccrs_link import ccrs_pkg::*; (
  input  ccrs_in_t    item,
  input  ccrs_state_t cur,
  input  ccrs_cfg_t   cfg,
  output ccrs_out_t   result,
  output ccrs_state_t state_next
);

  logic [31:0] clus;
  logic [31:0] rem;
  logic [31:0] base_loaded;
  logic        go;
  logic [7:0]  spc;
  logic [16:0] cbytes;
  logic [16:0] bytes;
  logic [17:0] rounded;
  logic        in_range;
  logic [31:0] cluster_offset;

  always_comb begin
    if (item.req_type == REQ_START) begin
      clus        = item.cluster_value;
      rem         = item.file_length;
      base_loaded = '0;
      go          = 1'b1;
    end else begin
      // a failed fat read is treated as an end-of-chain marker
      clus        = item.fat_read_failed ? CHAIN_END : (item.cluster_value & ENTRY_MASK);
      rem         = cur.remaining;
      base_loaded = cur.loaded;
      go          = cur.active;
    end
  end

  always_comb begin
    if (cfg.cluster_sectors == 8'd0) begin
      spc = 8'd1;
    end else if (cfg.cluster_sectors > MAX_CLUSTER_SECTORS) begin
      spc = MAX_CLUSTER_SECTORS;
    end else begin
      spc = cfg.cluster_sectors;
    end
  end

  assign cbytes   = {spc, 9'd0};
  assign bytes    = (rem < {15'd0, cbytes}) ? rem[16:0] : cbytes;
  assign rounded  = {1'b0, bytes} + SECTOR_ROUND;
  assign in_range = (rem != 32'd0) && (clus >= FIRST_DATA_CLUSTER) && (clus < CHAIN_END);
  assign cluster_offset = 32'((clus - FIRST_DATA_CLUSTER) * {24'd0, spc});

  always_comb begin
    result     = '0;
    state_next = cur;
    if (!go) begin
      // next entry with no file open leaves the state alone
      result.done_res     = 1'b1;
      result.loaded_total = cur.loaded;
    end else if (in_range) begin
      state_next.active    = 1'b1;
      state_next.remaining = rem - {15'd0, bytes};
      state_next.loaded    = base_loaded + {15'd0, bytes};
      result.issue_read    = 1'b1;
      result.read_lba      = cfg.data_base_lba + cluster_offset;
      result.read_sectors  = rounded[16:SECTOR_SHIFT];
      result.read_bytes    = bytes;
      // link offset is cluster * 4, split into sector and byte within sector
      result.lookup_lba    = cfg.fat_base_lba + {9'd0, clus[29:7]};
      result.lookup_offset = {clus[6:0], 2'b00};
      result.loaded_total  = base_loaded + {15'd0, bytes};
    end else begin
      state_next.active    = 1'b0;
      state_next.remaining = rem;
      state_next.loaded    = base_loaded;
      result.done_res      = 1'b1;
      result.loaded_total  = base_loaded;
    end
  end

endmodule

/* design/cluster_chain_read_sequencer_top.sv */
// cluster chain read sequencer top level: input register, link step, result register
// depends on ccrs_pkg and ccrs_link
//
// Walks a FAT32 cluster chain one link per transaction. A start transaction
// opens a file; each next transaction carries the FAT entry of the cluster
// just read and yields the next data read plus the FAT location of the link
// after it. Every transaction gives exactly one result, which is registered
// from the input register through the link step into the result register
// when the result side is free. A new transaction is accepted every
// cycle while the result side keeps up. The file state loop (remaining and
// loaded bytes) closes through the link step into the state register and
// so bounds the accept rate. Write the configuration registers only while
// no transaction is in flight.
module cluster_chain_read_sequencer_top import ccrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  ccrs_in_t    req,
  output logic        res_valid,
  input  logic        res_stall,
  output ccrs_out_t   res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ccrs_cfg_t   cfg;
  ccrs_state_t state;
  ccrs_state_t state_next;
  ccrs_in_t    s1_item;
  logic        s1_valid;
  ccrs_out_t   step_result;
  logic        out_free;
  logic        advance;

  assign out_free  = !res_valid || !res_stall;
  assign advance   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_base_lba    <= '0;
      cfg.data_base_lba   <= '0;
      cfg.cluster_sectors <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAT_BASE_LBA:    cfg.fat_base_lba    <= cfg_data;
        CFG_DATA_BASE_LBA:   cfg.data_base_lba   <= cfg_data;
        CFG_CLUSTER_SECTORS: cfg.cluster_sectors <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_item <= req;
    end
  end

  ccrs_link u_link (
    .item       (s1_item),
    .cur        (state),
    .cfg        (cfg),
    .result     (step_result),
    .state_next (state_next)
  );

  // file state and result register move together
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (out_free) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

  a_read_xor_done: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.issue_read != res.done_res))
    else $error("result is neither a read nor a chain end, or both");

  a_sectors_cover_bytes: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.issue_read) |->
      (res.read_bytes != 17'd0) && ({res.read_sectors, 9'd0} >= res.read_bytes))
    else $error("read sector count does not cover read bytes");

  a_end_closes_file: assert property (@(posedge clk) disable iff (rst)
    (advance && step_result.done_res) |=> !state.active)
    else $error("file still active after chain end");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_item) && $stable(state)))
    else $error("pending transaction or file state changed while output blocked");

endmodule

/* bench/tb_cluster_chain_read_sequencer_top.sv */
// testbench for cluster_chain_read_sequencer_top: random-idling driver and monitor
// around a cycle-free model of the cluster chain walk; depends on ccrs_pkg and the rtl
module tb_cluster_chain_read_sequencer_top;
  import ccrs_pkg::*;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned LINK_BYTES   = 4;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  ccrs_in_t    req = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  ccrs_out_t   res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cluster_chain_read_sequencer_top u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the registers and the file state
  logic [31:0] shadow_fat_lba = '0;
  logic [31:0] shadow_data_lba = '0;
  logic [7:0]  shadow_spc = 8'd1;
  logic        file_open = 1'b0;
  logic [31:0] bytes_left = '0;
  logic [31:0] bytes_loaded = '0;

  ccrs_in_t  pending_reqs[$];
  ccrs_out_t expected_reads[$];
  ccrs_out_t want;
  bit        req_taken = 1'b0;
  bit        calm = 1'b0;
  int        req_gap = 0;
  int        res_gap = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        queued_items = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] eff_sectors(input logic [7:0] s);
    if (s == 8'd0) return 32'd1;
    if (s > MAX_CLUSTER_SECTORS) return {24'd0, MAX_CLUSTER_SECTORS};
    return {24'd0, s};
  endfunction

  // one chain link: the read it issues and the updated byte counts
  function automatic ccrs_out_t chain_predict(input ccrs_in_t t);
    ccrs_out_t   r;
    logic [31:0] clus, spc, cbytes, take, link;
    r = '0;
    if (t.req_type == REQ_NEXT && !file_open) begin
      r.done_res = 1'b1;
      r.loaded_total = bytes_loaded;
    end else begin
      if (t.req_type == REQ_START) begin
        // full 32 bits compared, so high bits in a start cluster end the chain
        clus = t.cluster_value;
        bytes_left = t.file_length;
        bytes_loaded = '0;
        file_open = 1'b1;
      end else begin
        clus = t.fat_read_failed ? CHAIN_END : (t.cluster_value & ENTRY_MASK);
      end
      if (bytes_left != 0 && clus >= FIRST_DATA_CLUSTER && clus < CHAIN_END) begin
        spc = eff_sectors(shadow_spc);
        cbytes = spc * SECTOR_BYTES;
        take = (bytes_left < cbytes) ? bytes_left : cbytes;
        link = clus * LINK_BYTES;
        bytes_loaded = bytes_loaded + take;
        bytes_left = bytes_left - take;
        r.issue_read = 1'b1;
        r.read_lba = shadow_data_lba + (clus - FIRST_DATA_CLUSTER) * spc;
        r.read_sectors = 8'((take + SECTOR_BYTES - 1) / SECTOR_BYTES);
        r.read_bytes = take[16:0];
        r.lookup_lba = shadow_fat_lba + link / SECTOR_BYTES;
        r.lookup_offset = 9'(link % SECTOR_BYTES);
        r.loaded_total = bytes_loaded;
      end else begin
        file_open = 1'b0;
        r.done_res = 1'b1;
        r.loaded_total = bytes_loaded;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // driver: request side and result-side stall, both changed at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_stall <= 1'b0;
    end else begin
      if (req_valid && !req_taken) begin
        // hold the stalled transaction
      end else if (req_gap != 0) begin
        req_valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_reqs.size() == 0) begin
        req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        req_valid <= 1'b0;
        req_gap <= $urandom_range(0, 14);
      end else begin
        req_valid <= 1'b1;
        req <= pending_reqs[0];
      end

      if (res_gap != 0) begin
        res_stall <= 1'b1;
        res_gap <= res_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        res_gap <= $urandom_range(0, 14);
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted requests, compare accepted results in order
  always @(posedge clk) begin
    req_taken = !rst && req_valid && !req_stall;
    if (req_taken) begin
      expected_reads.push_back(chain_predict(req));
      void'(pending_reqs.pop_front());
    end
    if (!rst && res_valid && !res_stall) begin
      if (expected_reads.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, res);
        mismatch_count++;
      end else begin
        want = expected_reads.pop_front();
        check_field("issue_read", 32'(want.issue_read), 32'(res.issue_read));
        check_field("read_lba", want.read_lba, res.read_lba);
        check_field("read_sectors", 32'(want.read_sectors), 32'(res.read_sectors));
        check_field("read_bytes", 32'(want.read_bytes), 32'(res.read_bytes));
        check_field("lookup_lba", want.lookup_lba, res.lookup_lba);
        check_field("lookup_offset", 32'(want.lookup_offset), 32'(res.lookup_offset));
        check_field("done_res", 32'(want.done_res), 32'(res.done_res));
        check_field("loaded_total", want.loaded_total, res.loaded_total);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_cluster_chain_read_sequencer_top NOT OK");
      $finish;
    end
  end

  task automatic add_req(input logic kind, input logic [31:0] cval, fsize,
                         input logic failed);
    ccrs_in_t t;
    t.req_type = kind;
    t.cluster_value = cval;
    t.file_length = fsize;
    t.fat_read_failed = failed;
    pending_reqs.push_back(t);
    queued_items++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FAT_BASE_LBA:    shadow_fat_lba = val;
      CFG_DATA_BASE_LBA:   shadow_data_lba = val;
      CFG_CLUSTER_SECTORS: shadow_spc = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // block is idle once every queued transaction has produced its result
  task automatic drain;
    while (pending_reqs.size() != 0 || expected_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_cluster;
    case ($urandom_range(0, 3))
      0:       return $urandom_range(2, 20);
      1:       return $urandom_range(2, 32'h0FFF_FFF7);
      2:       return $urandom_range(0, 1) ? FIRST_DATA_CLUSTER : CHAIN_END - 1;
      default: return $urandom_range(2, 100000);
    endcase
  endfunction

  // a start plus its chain of links; a broken file ends its chain early
  task automatic queue_file(input bit broken);
    int          nreads, links, i;
    logic [31:0] cb, size, c, m;
    nreads = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    cb = eff_sectors(shadow_spc) * SECTOR_BYTES;
    case ($urandom_range(0, 15))
      0:       size = '0;
      1:       size = $urandom;
      default: size = (nreads - 1) * cb + $urandom_range(1, cb);
    endcase
    links = broken ? $urandom_range(0, nreads - 1) : nreads - 1;
    add_req(REQ_START, pick_cluster(), size, 1'($urandom_range(0, 1)));
    for (i = 0; i < links; i++) begin
      c = pick_cluster();
      m = $urandom;
      add_req(REQ_NEXT, {m[31:28], c[27:0]}, $urandom, 1'b0);
    end
    c = pick_cluster();
    m = $urandom;
    case ($urandom_range(0, broken ? 2 : 3))
      0:       add_req(REQ_NEXT, {m[31:28], 25'h1FF_FFFF, m[2:0]}, m, 1'b0);
      1:       add_req(REQ_NEXT, m, $urandom, 1'b1);
      2:       add_req(REQ_NEXT, {m[31:28], 27'd0, m[0]}, m, 1'b0);
      default: add_req(REQ_NEXT, {m[31:28], c[27:0]}, m, 1'b0);
    endcase
    // stray link after the chain has closed
    if (broken && $urandom_range(0, 1) == 1) begin
      pending_reqs.push_back(ccrs_in_t'({REQ_NEXT, $urandom, $urandom, 1'($urandom)}));
    end
  endtask

  initial begin
    int p, goal;
    logic [31:0] fat_v, data_v, spc_v;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: reset registers, one-sector clusters
    add_req(REQ_NEXT, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);   // link with no file open
    add_req(REQ_START, 32'd2, 32'd1, 1'b0);
    add_req(REQ_NEXT, 32'hFFFF_FFFF, 32'd0, 1'b0);
    add_req(REQ_START, CHAIN_END - 1, 32'hFFFF_FFFF, 1'b0);
    add_req(REQ_NEXT, 32'hFFFF_FFF7, 32'd0, 1'b0);           // masked to a valid cluster
    add_req(REQ_NEXT, 32'd5, 32'd0, 1'b1);                   // failed fat read
    add_req(REQ_START, 32'd1, 32'd100, 1'b0);
    add_req(REQ_START, 32'd0, 32'd100, 1'b0);
    add_req(REQ_START, 32'hF000_0005, 32'd100, 1'b0);
    add_req(REQ_START, 32'd5, 32'd0, 1'b0);
    add_req(REQ_START, CHAIN_END, 32'h1000, 1'b0);
    add_req(REQ_START, 32'd3, 32'd512, 1'b1);                // failed flag ignored on start
    add_req(REQ_NEXT, 32'd4, 32'd0, 1'b0);                   // no bytes left
    add_req(REQ_NEXT, 32'd4, 32'd0, 1'b0);
    add_req(REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_req(REQ_START, 32'd10, 32'd1000, 1'b0);
    add_req(REQ_NEXT, 32'd0, 32'd0, 1'b0);
    add_req(REQ_START, 32'd10, 32'd1000, 1'b0);
    add_req(REQ_NEXT, 32'h8000_0001, 32'd0, 1'b0);
    add_req(REQ_START, 32'd2, 32'h0001_0000, 1'b0);
    add_req(REQ_NEXT, 32'h0FFF_FFF6, 32'd0, 1'b0);
    add_req(REQ_NEXT, CHAIN_END, 32'd0, 1'b0);
    drain();

    goal = queued_items;
    for (p = 0; p < PHASES; p++) begin
      fat_v = $urandom;
      data_v = $urandom;
      spc_v = $urandom_range(0, 255);
      case (p)
        0: begin fat_v = '0; data_v = '0; spc_v = 32'd1; end
        1: begin fat_v = '1; data_v = '1; spc_v = 32'd128; end
        2: spc_v = 32'd0;
        3: spc_v = 32'd255;
        4: spc_v = $urandom_range(1, 128);
        default: ;
      endcase
      write_reg(CFG_FAT_BASE_LBA, fat_v);
      write_reg(CFG_DATA_BASE_LBA, data_v);
      write_reg(CFG_CLUSTER_SECTORS, spc_v);
      if (p == PHASES - 1) calm = 1'b1;
      goal += PHASE_ITEMS;
      while (queued_items < goal) begin
        case ($urandom_range(0, 9))
          7, 8:    queue_file(1'b1);
          9:       add_req(1'($urandom_range(0, 1)), $urandom, $urandom,
                           1'($urandom_range(0, 1)));
          default: queue_file(1'b0);
        endcase
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_cluster_chain_read_sequencer_top OK");
    end else begin
      $display("tb_cluster_chain_read_sequencer_top NOT OK");
    end
    $finish;
  end

endmodule
